// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL.
// Depends on nothing; the user module supplies clk and rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(label, prop)
`define ASSERT_NEVER(label, expr)
`endif
`endif

// ----- rtl/bdlp_pkg.sv -----
// Types and constants for the button debounce / long-press block.
// No dependencies.
`default_nettype none
package bdlp_pkg;
  localparam int BUTTONS  = 8;
  localparam int LANES    = (BUTTONS > 8) ? 8 : BUTTONS;
  localparam int IDX_W    = (LANES > 1) ? $clog2(LANES) : 1;
  localparam logic [7:0] LANE_MASK = 8'((9'd1 << LANES) - 9'd1);

  localparam logic [15:0] DEBOUNCE_RESET   = 16'd50;
  localparam logic [15:0] LONG_PRESS_RESET = 16'd5000;

  typedef enum logic [1:0] {
    REG_DEBOUNCE   = 2'd0,
    REG_LONG_PRESS = 2'd1,
    REG_POLARITY   = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    EV_PRESS   = 2'd0,
    EV_RELEASE = 2'd1,
    EV_LONG    = 2'd2
  } ev_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  function automatic logic [15:0] at_least_one(input logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction
endpackage
`default_nettype wire

// ----- rtl/button_debounce_long_press_core.sv -----
// Top level of the button debounce / long-press block.
// Depends on bdlp_pkg and assert_macros.svh.
//
// One input word is one tick with the raw levels of the buttons. A small
// sequencer walks the buttons with one shared 16-bit decrement-and-test
// unit: per button a debounce countdown step, then a long-press countdown
// step; after the last button a flush state, then back to idle. A new input
// word is taken only when idle; the scan and the flush hold while the
// output word is stalled. Events leave in ascending button order, one word
// each; the final event of a tick has last set. in_ready is high only
// while the sequencer is idle. Configuration writes are taken every cycle
// and must only be issued while idle.
`default_nettype none
`include "assert_macros.svh"
module button_debounce_long_press_core
  import bdlp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  levels,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       button,
  output logic [1:0]       event_res,
  output logic             last
);

  state_t state, state_next;

  logic [15:0]      debounce_ticks;
  logic [15:0]      long_press_ticks;
  logic             press_low;

  logic [LANES-1:0] lv;
  logic [LANES-1:0] prev;
  logic [LANES-1:0] drun;
  logic [LANES-1:0] hrun;
  logic [15:0]      dcnt [LANES];
  logic [15:0]      hcnt [LANES];

  logic [IDX_W-1:0] idx;
  logic             phase;
  logic             touched;

  logic             pend_valid;
  logic [2:0]       pend_button;
  ev_t              pend_ev;

  logic             cur_bit;
  logic             changed;
  logic             pressed;
  logic [15:0]      dec_in;
  logic [15:0]      dec_out;
  logic             dec_zero;
  logic             ev_fire;
  ev_t              ev_code;
  logic             out_free;
  logic             stall;
  logic             advance;
  logic             scan_end;
  logic             out_load;

  // shared decrement unit and event decode
  always_comb begin
    cur_bit  = lv[idx];
    changed  = cur_bit ^ prev[idx];
    pressed  = (cur_bit != press_low);
    dec_in   = phase ? hcnt[idx] : dcnt[idx];
    dec_out  = dec_in - 16'd1;
    dec_zero = (dec_out == 16'd0);
    ev_fire  = 1'b0;
    ev_code  = EV_PRESS;
    if (!phase) begin
      if (!changed && drun[idx] && dec_zero) begin
        ev_fire = 1'b1;
        ev_code = pressed ? EV_PRESS : EV_RELEASE;
      end
    end else begin
      if (!touched && hrun[idx] && dec_zero) begin
        ev_fire = 1'b1;
        ev_code = EV_LONG;
      end
    end
  end

  assign out_free = !out_valid || out_ready;
  assign stall    = ev_fire && pend_valid && !out_free;
  assign advance  = (state == ST_SCAN) && !stall;
  assign scan_end = phase && (idx == IDX_W'(LANES - 1));
  assign out_load = (advance && ev_fire && pend_valid) ||
                    (state == ST_FLUSH && pend_valid && out_free);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_SCAN;
      ST_SCAN:  if (advance && scan_end) state_next = ST_FLUSH;
      ST_FLUSH: if (!pend_valid || out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == ST_IDLE);
    cfg_ready = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      debounce_ticks   <= DEBOUNCE_RESET;
      long_press_ticks <= LONG_PRESS_RESET;
      press_low        <= 1'b1;
      prev             <= LANE_MASK[LANES-1:0];
      drun             <= '0;
      hrun             <= '0;
      idx              <= '0;
      phase            <= 1'b0;
      touched          <= 1'b0;
      pend_valid       <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_DEBOUNCE:   debounce_ticks   <= cfg_data;
          REG_LONG_PRESS: long_press_ticks <= cfg_data;
          REG_POLARITY:   press_low        <= cfg_data[0];
          default: ;
        endcase
      end

      if (out_load) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;

      if (in_valid && in_ready) begin
        lv    <= levels[LANES-1:0];
        idx   <= '0;
        phase <= 1'b0;
      end

      if (advance) begin
        if (!phase) begin
          prev[idx] <= cur_bit;
          touched   <= !changed && drun[idx] && dec_zero;
          if (changed) begin
            dcnt[idx] <= at_least_one(debounce_ticks);
            drun[idx] <= 1'b1;
          end else if (drun[idx]) begin
            dcnt[idx] <= dec_out;
            if (dec_zero) begin
              drun[idx] <= 1'b0;
              if (pressed) begin
                hcnt[idx] <= at_least_one(long_press_ticks);
                hrun[idx] <= 1'b1;
              end else begin
                hrun[idx] <= 1'b0;
              end
            end
          end
          phase <= 1'b1;
        end else begin
          if (!touched && hrun[idx]) begin
            hcnt[idx] <= dec_out;
            if (dec_zero) hrun[idx] <= 1'b0;
          end
          phase <= 1'b0;
          idx   <= scan_end ? '0 : idx + IDX_W'(1);
        end

        if (ev_fire) begin
          if (pend_valid) begin
            button    <= pend_button;
            event_res <= pend_ev;
            last      <= 1'b0;
          end
          pend_valid  <= 1'b1;
          pend_button <= 3'(idx);
          pend_ev     <= ev_code;
        end
      end

      if (state == ST_FLUSH && pend_valid && out_free) begin
        button     <= pend_button;
        event_res  <= pend_ev;
        last       <= 1'b1;
        pend_valid <= 1'b0;
      end
    end
  end

  `ASSERT_NEVER(a_idle_no_pending, state == ST_IDLE && pend_valid)
  `ASSERT_CLK(a_accept_starts_scan, in_valid && in_ready |=> state == ST_SCAN)
  `ASSERT_CLK(a_flush_exit, state == ST_FLUSH && !pend_valid |=> state == ST_IDLE)
  `ASSERT_NEVER(a_hold_touched_phase, state == ST_IDLE && phase)

endmodule
`default_nettype wire

// ----- verif/button_debounce_long_press_core_tb.sv -----
// Testbench for button_debounce_long_press_core: drives raw button ticks and register
// writes, predicts the press/release/long-press words and checks them in order.
// Depends on bdlp_pkg and the core RTL.
`default_nettype none
module button_debounce_long_press_core_tb;
  import bdlp_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 40;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [2:0] button;
    ev_t        kind;
    logic       last;
  } tick_word_t;

  class debounce_scoreboard;
    logic [15:0]   debounce_ticks;
    logic [15:0]   long_press_ticks;
    logic          press_low;
    logic [7:0]    prev_levels;
    logic [15:0]   settle_left[LANES];
    logic [7:0]    settling;
    logic [15:0]   hold_left[LANES];
    logic [7:0]    holding;
    tick_word_t    expected_events[$];
    int unsigned   ticks_seen;
    int unsigned   events_seen;
    int unsigned   mismatches;

    function new();
      debounce_ticks   = DEBOUNCE_RESET;
      long_press_ticks = LONG_PRESS_RESET;
      press_low        = 1'b1;
      prev_levels      = 8'hFF & LANE_MASK;
      settling         = '0;
      holding          = '0;
      foreach (settle_left[i]) begin
        settle_left[i] = '0;
        hold_left[i]   = '0;
      end
      ticks_seen  = 0;
      events_seen = 0;
      mismatches  = 0;
    endfunction

    function void set_reg(input logic [1:0] idx, input logic [15:0] data);
      case (idx)
        REG_DEBOUNCE:   debounce_ticks   = data;
        REG_LONG_PRESS: long_press_ticks = data;
        REG_POLARITY:   press_low        = data[0];
        default: ;
      endcase
    endfunction

    function void note_tick(input logic [7:0] raw);
      logic [7:0]    lv;
      logic          hold_touched;
      tick_word_t    ev;
      tick_word_t    fresh[$];
      lv = raw & LANE_MASK;
      ticks_seen++;
      for (int i = 0; i < LANES; i++) begin
        hold_touched = 1'b0;
        ev.button = i[2:0];
        ev.last   = 1'b0;
        if (lv[i] != prev_levels[i]) begin
          settle_left[i] = (debounce_ticks == 16'd0) ? 16'd1 : debounce_ticks;
          settling[i]    = 1'b1;
        end else if (settling[i]) begin
          settle_left[i] = settle_left[i] - 16'd1;
          if (settle_left[i] == 16'd0) begin
            settling[i]  = 1'b0;
            hold_touched = 1'b1;
            if (lv[i] == !press_low) begin
              hold_left[i] = (long_press_ticks == 16'd0) ? 16'd1 : long_press_ticks;
              holding[i]   = 1'b1;
              ev.kind      = EV_PRESS;
            end else begin
              holding[i] = 1'b0;
              ev.kind    = EV_RELEASE;
            end
            fresh.push_back(ev);
          end
        end
        if (!hold_touched && holding[i]) begin
          hold_left[i] = hold_left[i] - 16'd1;
          if (hold_left[i] == 16'd0) begin
            holding[i] = 1'b0;
            ev.kind    = EV_LONG;
            fresh.push_back(ev);
          end
        end
      end
      prev_levels = lv;
      for (int k = 0; k < fresh.size(); k++) begin
        ev      = fresh[k];
        ev.last = (k == fresh.size() - 1);
        expected_events.push_back(ev);
      end
    endfunction

    function void check_event(input logic [2:0] b, input logic [1:0] kind, input logic lst);
      tick_word_t want;
      events_seen++;
      if (expected_events.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected word: button %0d kind %0d last %0b", b, kind, lst);
        return;
      end
      want = expected_events.pop_front();
      if (want.button !== b || want.kind !== kind || want.last !== lst) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("word %0d: expected button %0d kind %0d last %0b, got %0d %0d %0b",
                   events_seen, want.button, want.kind, want.last, b, kind, lst);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  levels;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  button;
  logic [1:0]  event_res;
  logic        last;

  debounce_scoreboard board;
  logic [7:0]  raw_levels = 8'hFF;
  int          sink_mode = 0;
  logic [7:0]  stall_phase = '0;
  int unsigned cycle_count = 0;
  int unsigned reg_writes = 0;

  button_debounce_long_press_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .levels    (levels),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .button    (button),
    .event_res (event_res),
    .last      (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // hold off the output on a pattern set per phase
  always @(negedge clk) begin
    stall_phase <= stall_phase + 8'd1;
    case (sink_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= 1'($urandom_range(1));
      2:       out_ready <= (stall_phase[2:0] == 3'd0);
      default: out_ready <= ($urandom_range(7) != 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_event(button, event_res, last);
  end

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(idx, data);
    reg_writes++;
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  task automatic send_tick(input logic [7:0] lv);
    @(negedge clk);
    in_valid <= 1'b1;
    levels   <= lv;
    do @(posedge clk); while (!in_ready);
    board.note_tick(lv);
  endtask

  // drop valid, drain every expected word, then let the last tick finish
  task automatic wait_idle();
    @(negedge clk) in_valid <= 1'b0;
    while (board.expected_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_ticks(input int count, input int flip_odds, input bit bursty);
    int         burst_left;
    logic [7:0] next_lv;
    burst_left = $urandom_range(1, 24);
    for (int t = 0; t < count; t++) begin
      if ($urandom_range(9) == 0) begin
        next_lv = 8'($urandom);
      end else begin
        next_lv = raw_levels;
        for (int b = 0; b < 8; b++)
          if ($urandom_range(flip_odds - 1) == 0) next_lv[b] = ~next_lv[b];
      end
      raw_levels = next_lv;
      send_tick(raw_levels);
      burst_left--;
      if (bursty && burst_left == 0) begin
        @(negedge clk) in_valid <= 1'b0;
        repeat ($urandom_range(0, 39)) @(negedge clk);
        burst_left = $urandom_range(1, 24);
      end
    end
  endtask

  initial begin
    logic [7:0] corners[8] = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80, 8'hFE, 8'h7F};
    logic [7:0] presses[6] = '{8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF};
    logic [7:0] overlaps[7] = '{8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00};
    int         odds_pick[4] = '{2, 6, 12, 24};
    rst       = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = REG_DEBOUNCE;
    cfg_data  = '0;
    in_valid  = 1'b0;
    levels    = '0;
    out_ready = 1'b0;
    board     = new();
    repeat (10) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    foreach (corners[k]) send_tick(corners[k]);
    wait_idle();
    write_reg(REG_DEBOUNCE, 16'd0);
    write_reg(REG_LONG_PRESS, 16'd0);
    write_reg(REG_POLARITY, 16'd1);
    foreach (presses[k]) send_tick(presses[k]);
    wait_idle();
    write_reg(REG_LONG_PRESS, 16'd2);
    write_reg(REG_UNUSED, 16'hFFFF);
    foreach (overlaps[k]) send_tick(overlaps[k]);
    raw_levels = overlaps[6];

    for (int phase = 0; phase < 9; phase++) begin
      wait_idle();
      sink_mode = phase % 4;
      case (phase)
        0: begin
          write_reg(REG_DEBOUNCE, 16'hFFFF);
          write_reg(REG_LONG_PRESS, 16'hFFFF);
        end
        1: begin
          write_reg(REG_DEBOUNCE, 16'd1);
          write_reg(REG_LONG_PRESS, 16'hFFFF);
          write_reg(REG_POLARITY, 16'hFFFE);
        end
        default: begin
          write_reg(REG_DEBOUNCE, 16'($urandom_range(0, 4)));
          write_reg(REG_LONG_PRESS, 16'($urandom_range(0, 12)));
          write_reg(REG_POLARITY, 16'($urandom));
          if ($urandom_range(2) == 0) write_reg(REG_UNUSED, 16'($urandom));
        end
      endcase
      run_ticks((phase == 0) ? 20 : 60, odds_pick[$urandom_range(3)], phase != 3);
    end
    wait_idle();

    $display("covered %0d ticks, %0d event words, %0d register writes",
             board.ticks_seen, board.events_seen, reg_writes);
    $display("mismatches: %0d (debounce/long-press periods from zero up to full scale)",
             board.mismatches);
    if (board.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- files.f -----
+incdir+rtl
rtl/bdlp_pkg.sv
rtl/button_debounce_long_press_core.sv
verif/button_debounce_long_press_core_tb.sv
